// ===== sv/reliable_receiver_reorder_top_defines.svh =====
// Assertion macros for the reliable receiver checker.
`ifndef RELIABLE_RECEIVER_REORDER_TOP_DEFINES_SVH
`define RELIABLE_RECEIVER_REORDER_TOP_DEFINES_SVH
// implication checked every clock outside reset
`define RRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrr check failed");
// next-cycle implication checked outside reset
`define RRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrr check failed");
`endif

// ===== sv/rrr_pkg.sv =====
// Shared types and codes for the reliable receiver.
`default_nettype none
package rrr_pkg;
  localparam logic [1:0] KIND_CTRL = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // input opcodes
  localparam logic OP_PKT  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] len;
    logic [31:0] seq;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seg_seq;
    logic [15:0] seg_len;
    logic [7:0]  seg_tag;
    logic [31:0] ack_num;
    logic        syn_out;
    logic        ack_out;
    logic        fin_out;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/rrr_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== sv/rrr_outreg.sv =====
// Output register holding one result item for the master-side stream.
`default_nettype none
module rrr_outreg import rrr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire result_t     res,
  output logic             free,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  logic    vld_r;
  result_t res_r;

  assign free = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
    if (free && load) res_r <= res;
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {5'd0, res_r.fin_out, res_r.ack_out, res_r.syn_out, res_r.ack_num,
                       res_r.seg_tag, res_r.seg_len, res_r.seg_seq};
endmodule
`default_nettype wire

// ===== sv/reliable_receiver_reorder_top.sv =====
// Top level: reliable receiver with out-of-order table and cumulative ACKs.
//
//  channel | dir | fields
//  in_*    | in  | tuser: opcode; tdata: csum, syn, ack, fin, data, seq, len, tag
//  out_*   | out | tuser: kind; tlast: last; tdata: seq, len, tag, ack_num, syn, ack, fin
//
// Flow: an item is taken in S_IDLE; each result item is then loaded into the
// output register from S_OUT, and the closing ACK after a segment and the
// FIN after a FIN's ACK are first built in S_ACK and S_FIN2. An ignored item
// yields no result, and the block stays in S_IDLE.
// Table walks (store or drain) visit each entry through S_RD and S_CMP, up
// to BUF_DEPTH entries per pass; a drain restarts its pass after every hit.
// The RAM's registered read port is why each entry needs the S_RD step.
// Reset: synchronous; valid bits are flip-flops, so no clearing pass.
// Stalls: results wait in the output register; the next item is taken once
// the last result of the current one has been loaded there.
`default_nettype none
module reliable_receiver_reorder_top import rrr_pkg::*; #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // csum, syn, ack, fin, data, seq[31:0], len[15:0], tag[7:0]
  input  wire logic [0:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // seq, len, tag, ack_num, syn, ack, fin
  output logic [1:0]       out_tuser,  // kind
  output logic             out_tlast
);
  localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(BUF_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD = 6'b000010, S_CMP = 6'b000100,
    S_OUT  = 6'b001000, S_FIN2 = 6'b010000, S_ACK = 6'b100000
  } state_t;
  typedef enum logic [2:0] {
    C_IDLE = 3'b001, C_CONN = 3'b010, C_FINW = 3'b100
  } conn_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  conn_t  conn_r, conn_nxt;
  logic   await_r, await_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [BUF_DEPTH-1:0] valid_r, valid_nxt;
  logic [IW-1:0] idx_r, idx_nxt, free_idx_r, free_idx_nxt;
  logic   free_found_r, free_found_nxt, drain_r, drain_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [7:0]  ptag_r, ptag_nxt;
  result_t res_r, res_nxt;

  logic  wr_en, out_free, out_load, hit, free_now;
  logic [IW-1:0] wr_addr, free_sel;
  slot_t wr_data, rd_data;

  // input fields
  logic f_op, f_csum, f_syn, f_ack, f_fin, f_data;
  logic [31:0] f_seq;
  logic [15:0] f_len;
  logic [7:0]  f_tag;
  assign f_op   = in_tuser[0];
  assign f_csum = in_tdata[0];
  assign f_syn  = in_tdata[1];
  assign f_ack  = in_tdata[2];
  assign f_fin  = in_tdata[3];
  assign f_data = in_tdata[4];
  assign f_seq  = in_tdata[36:5];
  assign f_len  = in_tdata[52:37];
  assign f_tag  = in_tdata[60:53];

  assign in_tready = (state_r == S_IDLE);

  rrr_ram #(.WIDTH($bits(slot_t)), .DEPTH(BUF_DEPTH)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr(idx_r), .rd_data
  );

  rrr_outreg u_out (
    .clk, .rst_n, .load(out_load), .res(res_r), .free(out_free),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  // entry under compare matches the walk's key
  assign hit      = valid_r[idx_r] && (rd_data.seq == (drain_r ? exp_r : key_r));
  assign free_now = free_found_r || !valid_r[idx_r];
  assign free_sel = free_found_r ? free_idx_r : idx_r;
  assign out_load = (state_r == S_OUT);

  function automatic result_t ctrl(input logic [31:0] a, input logic s, input logic k,
                                   input logic f, input logic l);
    result_t r;
    r = '0;
    r.kind = KIND_CTRL; r.ack_num = a; r.syn_out = s; r.ack_out = k;
    r.fin_out = f; r.last = l;
    return r;
  endfunction

  function automatic result_t seg(input logic [1:0] kd, input logic [31:0] s,
                                  input logic [15:0] l, input logic [7:0] t);
    result_t r;
    r = '0;
    r.kind = kd; r.seg_seq = s; r.seg_len = l; r.seg_tag = t;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; conn_nxt = conn_r; await_nxt = await_r;
    exp_nxt = exp_r; valid_nxt = valid_r; idx_nxt = idx_r; free_idx_nxt = free_idx_r;
    free_found_nxt = free_found_r; drain_nxt = drain_r; key_nxt = key_r;
    plen_nxt = plen_r; ptag_nxt = ptag_r; res_nxt = res_r;
    wr_en = 1'b0; wr_addr = idx_r;
    wr_data = '{tag: ptag_r, len: plen_r, seq: key_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt = f_seq; plen_nxt = f_len; ptag_nxt = f_tag;
          if (conn_r == C_FINW) begin
            if (f_op == OP_PKT && f_ack) begin
              conn_nxt = C_IDLE; await_nxt = 1'b1; exp_nxt = '0;
            end else begin
              res_nxt = ctrl('0, 1'b0, 1'b0, 1'b1, 1'b1);
              ret_nxt = S_IDLE; state_nxt = S_OUT;
            end
          end else if (f_op == OP_PKT && f_csum) begin
            if (conn_r != C_CONN) begin
              if (f_syn) begin
                conn_nxt = C_CONN; valid_nxt = '0; exp_nxt = f_seq + 32'd1;
                res_nxt = ctrl(f_seq + 32'd1, 1'b1, 1'b1, 1'b0, 1'b1);
                ret_nxt = S_IDLE; state_nxt = S_OUT;
              end
            end else if (f_fin) begin
              res_nxt = ctrl(f_seq + 32'd1, 1'b0, 1'b1, 1'b0, 1'b0);
              conn_nxt = C_FINW; ret_nxt = S_FIN2; state_nxt = S_OUT;
            end else if (f_data) begin
              idx_nxt = '0; free_found_nxt = 1'b0;
              if (f_seq == exp_r) begin
                exp_nxt = exp_r + 32'(f_len);
                state_nxt = S_OUT;
                if (await_r) begin
                  await_nxt = 1'b0;
                  res_nxt = seg(KIND_NAME, f_seq, f_len, f_tag);
                  ret_nxt = S_ACK;
                end else begin
                  res_nxt = seg(KIND_DATA, f_seq, f_len, f_tag);
                  drain_nxt = 1'b1; ret_nxt = S_RD;
                end
              end else if (f_seq > exp_r) begin
                drain_nxt = 1'b0; state_nxt = S_RD;
              end else begin
                state_nxt = S_ACK;
              end
            end
          end
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (drain_r) begin
          if (hit) begin
            valid_nxt[idx_r] = 1'b0;
            exp_nxt = exp_r + 32'(rd_data.len);
            res_nxt = seg(KIND_DATA, rd_data.seq, rd_data.len, rd_data.tag);
            idx_nxt = '0; ret_nxt = S_RD; state_nxt = S_OUT;
          end else if (idx_r == IDX_LAST) begin
            state_nxt = S_ACK;
          end else begin
            idx_nxt = idx_r + IW'(1); state_nxt = S_RD;
          end
        end else begin
          free_found_nxt = free_now; free_idx_nxt = free_sel;
          if (hit) begin
            wr_en = 1'b1; wr_addr = idx_r; valid_nxt[idx_r] = 1'b1;
            state_nxt = S_ACK;
          end else if (idx_r == IDX_LAST) begin
            // lowest free entry; a full table drops the item, still ACKed
            if (free_now) begin
              wr_en = 1'b1; wr_addr = free_sel; valid_nxt[free_sel] = 1'b1;
            end
            state_nxt = S_ACK;
          end else begin
            idx_nxt = idx_r + IW'(1); state_nxt = S_RD;
          end
        end
      end
      S_OUT: if (out_free) state_nxt = ret_r;
      S_FIN2: begin
        res_nxt = ctrl('0, 1'b0, 1'b0, 1'b1, 1'b1);
        ret_nxt = S_IDLE; state_nxt = S_OUT;
      end
      S_ACK: begin
        res_nxt = ctrl(exp_r, 1'b0, 1'b1, 1'b0, 1'b1);
        ret_nxt = S_IDLE; state_nxt = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_IDLE; conn_r <= C_IDLE;
      await_r <= 1'b1; exp_r <= '0; valid_r <= '0;
      idx_r <= '0; free_found_r <= 1'b0; drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ret_r <= ret_nxt; conn_r <= conn_nxt;
      await_r <= await_nxt; exp_r <= exp_nxt; valid_r <= valid_nxt;
      idx_r <= idx_nxt; free_found_r <= free_found_nxt; drain_r <= drain_nxt;
    end
    free_idx_r <= free_idx_nxt; key_r <= key_nxt; plen_r <= plen_nxt;
    ptag_r <= ptag_nxt; res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/rrr_checker.sv =====
// Port-level checker for the reliable receiver, bound to the top level.
`default_nettype none
`include "reliable_receiver_reorder_top_defines.svh"
module rrr_sva import rrr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);
  `RRR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RRR_ASSERT_IMP(a_kind_ok, out_tvalid, out_tuser == KIND_CTRL || out_tuser == KIND_NAME || out_tuser == KIND_DATA)
  `RRR_ASSERT_IMP(a_ctrl_clean, out_tvalid && out_tuser == KIND_CTRL, out_tdata[55:0] == 56'd0)
  `RRR_ASSERT_IMP(a_seg_clean, out_tvalid && out_tuser != KIND_CTRL, out_tdata[90:56] == 35'd0 && !out_tlast)
endmodule

bind reliable_receiver_reorder_top rrr_sva u_rrr_sva (.*);
`default_nettype wire

// ===== tb/rrr_checker.sv =====
// Scoreboard for the reliable receiver: predicts results and compares them.
`timescale 1ns / 100ps
`default_nettype none
module rrr_checker import rrr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               fails,
  output int               pending
);
  localparam logic [1:0] LINK_IDLE = 2'd0;
  localparam logic [1:0] LINK_OPEN = 2'd1;
  localparam logic [1:0] LINK_FINW = 2'd2;

  logic [1:0]  link;
  bit          want_name;
  logic [31:0] next_seq;
  bit          held_ok [DEPTH];
  logic [31:0] held_seq [DEPTH];
  logic [15:0] held_len [DEPTH];
  logic [7:0]  held_tag [DEPTH];
  result_t     exp_q [$];
  result_t     step_q [$];

  function automatic void push_ctrl(logic [31:0] an, bit s, bit a, bit f);
    result_t r;
    r = '0;
    r.kind = KIND_CTRL; r.ack_num = an; r.syn_out = s; r.ack_out = a; r.fin_out = f;
    step_q.push_back(r);
  endfunction

  function automatic void push_seg(logic [1:0] k, logic [31:0] s, logic [15:0] l,
                                   logic [7:0] t);
    result_t r;
    r = '0;
    r.kind = k; r.seg_seq = s; r.seg_len = l; r.seg_tag = t;
    step_q.push_back(r);
  endfunction

  // next state and results of one header or tick
  function automatic void predict_hdr(logic [0:0] op, logic [63:0] d);
    bit          csum, syn, ack, fin, dat, hit;
    logic [31:0] seq;
    logic [15:0] len;
    logic [7:0]  tag;
    int          pick;
    csum = d[0]; syn = d[1]; ack = d[2]; fin = d[3]; dat = d[4];
    seq = d[36:5]; len = d[52:37]; tag = d[60:53];
    step_q.delete();
    if (link == LINK_FINW) begin
      if (op != OP_TICK && ack) begin
        link = LINK_IDLE; want_name = 1; next_seq = '0;
      end else begin
        push_ctrl('0, 0, 0, 1);
      end
    end else if (op == OP_TICK || !csum) begin
    end else if (link != LINK_OPEN) begin
      if (syn) begin
        link = LINK_OPEN;
        foreach (held_ok[i]) held_ok[i] = 0;
        next_seq = seq + 32'd1;
        push_ctrl(next_seq, 1, 1, 0);
      end
    end else if (fin) begin
      push_ctrl(seq + 32'd1, 0, 1, 0);
      push_ctrl('0, 0, 0, 1);
      link = LINK_FINW;
    end else if (dat) begin
      if (seq == next_seq) begin
        if (want_name) begin
          push_seg(KIND_NAME, seq, len, tag);
          want_name = 0;
          next_seq += 32'(len);
        end else begin
          push_seg(KIND_DATA, seq, len, tag);
          next_seq += 32'(len);
          hit = 1;
          while (hit) begin
            hit = 0;
            for (int i = 0; i < DEPTH && !hit; i++)
              if (held_ok[i] && held_seq[i] == next_seq) begin
                push_seg(KIND_DATA, held_seq[i], held_len[i], held_tag[i]);
                held_ok[i] = 0;
                next_seq += 32'(held_len[i]);
                hit = 1;
              end
          end
        end
      end else if (seq > next_seq) begin
        pick = -1;
        for (int i = 0; i < DEPTH && pick < 0; i++)
          if (held_ok[i] && held_seq[i] == seq) pick = i;
        for (int i = 0; i < DEPTH && pick < 0; i++)
          if (!held_ok[i]) pick = i;
        if (pick >= 0) begin
          held_ok[pick] = 1; held_seq[pick] = seq;
          held_len[pick] = len; held_tag[pick] = tag;
        end
      end
      push_ctrl(next_seq, 0, 1, 0);
    end
    if (step_q.size() > 0) step_q[$].last = 1;
    foreach (step_q[i]) exp_q.push_back(step_q[i]);
  endfunction

  function automatic void cmp(string fld, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fld, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      link = LINK_IDLE; want_name = 1; next_seq = '0;
      foreach (held_ok[i]) held_ok[i] = 0;
      exp_q.delete();
      fails = 0;
    end else begin
      // an item's results never leave in the cycle it is taken
      if (in_tvalid && in_tready) predict_hdr(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (exp_q.size() == 0) begin
          $error("result with no expectation: %h kind %0d", out_tdata, out_tuser);
          fails++;
        end else begin
          e = exp_q.pop_front();
          cmp("out_kind", 32'(e.kind), 32'(out_tuser));
          cmp("seg_seq", e.seg_seq, out_tdata[31:0]);
          cmp("seg_len", 32'(e.seg_len), 32'(out_tdata[47:32]));
          cmp("seg_tag", 32'(e.seg_tag), 32'(out_tdata[55:48]));
          cmp("ack_num", e.ack_num, out_tdata[87:56]);
          cmp("syn_out", 32'(e.syn_out), 32'(out_tdata[88]));
          cmp("ack_out", 32'(e.ack_out), 32'(out_tdata[89]));
          cmp("fin_out", 32'(e.fin_out), 32'(out_tdata[90]));
          cmp("last", 32'(e.last), 32'(out_tlast));
        end
      end
    end
    pending = exp_q.size();
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top: stimulus, stalls and verdict for the reliable receiver.
`timescale 1ns / 100ps
`default_nettype none
module tb import rrr_pkg::*;;

  localparam int BUF_DEPTH = 16;
  localparam int DRAIN_WAIT = 800;     // longest drain walk, with margin
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fails, pending;
  int          send_idle_pct = 0;  // sender gap odds, percent
  int          recv_idle_pct = 0;  // receiver stall odds, percent
  int          sent = 0;
  int          cycles = 0;

  reliable_receiver_reorder_top #(.BUF_DEPTH(BUF_DEPTH)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  rrr_checker #(.DEPTH(BUF_DEPTH)) scb (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fails, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("reliable_receiver_reorder_top regression: fail");
      $finish;
    end
  end

  function automatic bit rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [15:0] rand_len();
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rand_tag();
    return 8'($urandom);
  endfunction

  // one header onto the input channel; returns after it is taken
  task automatic send_hdr(bit op, bit csum, bit syn, bit ack, bit fin, bit dat,
                          logic [31:0] seq, logic [15:0] len, logic [7:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, tag, len, seq, dat, fin, ack, syn, csum};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic data_pkt(logic [31:0] seq, logic [15:0] len, logic [7:0] tag);
    send_hdr(OP_PKT, 1, 0, rand_bit(), 0, 1, seq, len, tag);
  endtask

  // anything at all: broken checksums, ticks, odd flag mixes
  task automatic noise();
    send_hdr(rand_bit(), rand_bit(), rand_bit(), rand_bit(), rand_bit(), rand_bit(),
             $urandom, rand_len(), rand_tag());
  endtask

  task automatic go_idle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one connection: SYN, a run of segments in order or scrambled, mostly a FIN close
  task automatic session();
    logic [31:0] sq [$];
    logic [15:0] ln [$];
    logic [7:0]  tg [$];
    logic [31:0] base, cur;
    logic [15:0] l;
    int          n, order, j;
    logic [31:0] ts;
    logic [15:0] tl;
    logic [7:0]  tt;
    n = $urandom_range(2, 24);
    order = $urandom_range(3);
    // mostly random sequence numbers, now and then right near the wrap point
    base = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
    send_hdr(OP_PKT, 1, 1, rand_bit(), 0, 0, base, rand_len(), rand_tag());
    cur = base + 1;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       l = 16'd0;
        1:       l = rand_len();
        default: l = 16'($urandom_range(1, 1500));
      endcase
      sq.push_back(cur); ln.push_back(l); tg.push_back(rand_tag());
      cur += 32'(l);
    end
    // name segment stays first except in the fully shuffled order
    if (order == 1) begin
      for (int i = 1; i + 1 < n; i++)
        if (rand_bit()) begin
          ts = sq[i]; sq[i] = sq[i+1]; sq[i+1] = ts;
          tl = ln[i]; ln[i] = ln[i+1]; ln[i+1] = tl;
          tt = tg[i]; tg[i] = tg[i+1]; tg[i+1] = tt;
        end
    end else if (order == 2) begin
      sq.reverse(); ln.reverse(); tg.reverse();
      ts = sq.pop_back(); tl = ln.pop_back(); tt = tg.pop_back();
      sq.push_front(ts); ln.push_front(tl); tg.push_front(tt);
    end else if (order == 3) begin
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(i);
        ts = sq[i]; sq[i] = sq[j]; sq[j] = ts;
        tl = ln[i]; ln[i] = ln[j]; ln[j] = tl;
        tt = tg[i]; tg[i] = tg[j]; tg[j] = tt;
      end
    end
    for (int i = 0; i < n; i++) begin
      data_pkt(sq[i], ln[i], tg[i]);
      if ($urandom_range(9) == 0) data_pkt(sq[i], ln[i], tg[i]);   // duplicate
      if ($urandom_range(11) == 0) noise();
    end
    // resend a random pick of the segments, so late drains happen
    if (order != 0)
      for (int i = 0; i < n; i++)
        if ($urandom_range(2) == 0) data_pkt(sq[i], ln[i], tg[i]);
    if ($urandom_range(5) != 0) begin
      send_hdr(OP_PKT, 1, rand_bit(), rand_bit(), 1, rand_bit(),
               $urandom, rand_len(), rand_tag());
      repeat ($urandom_range(2)) send_hdr(OP_TICK, rand_bit(), 0, 0, 0, 0,
                                          $urandom, rand_len(), rand_tag());
      if ($urandom_range(2) == 0)
        send_hdr(OP_PKT, rand_bit(), 1, 0, 1, 1, $urandom, rand_len(), rand_tag());
      if ($urandom_range(7) != 0)
        send_hdr(OP_PKT, rand_bit(), rand_bit(), 1, rand_bit(),
                 rand_bit(), $urandom, rand_len(), rand_tag());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: idle ignores, wrap on SYN, name, store, overwrite, drain,
    // duplicate, FIN over DATA, FIN-wait resends and close on a bad-checksum ACK
    send_hdr(OP_PKT, 1, 0, 1, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_hdr(OP_TICK, 1, 1, 1, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_hdr(OP_PKT, 0, 1, 0, 0, 0, 32'd5, 16'd0, 8'd0);
    send_hdr(OP_PKT, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 16'd0, 8'd0);     // expects 0
    send_hdr(OP_PKT, 1, 1, 1, 0, 0, 32'd77, 16'd1, 8'd1);           // repeated SYN
    send_hdr(OP_PKT, 1, 0, 0, 0, 0, 32'd0, 16'd1, 8'd1);            // no FIN, no DATA
    send_hdr(OP_PKT, 0, 0, 0, 0, 1, 32'd0, 16'd10, 8'h11);          // bad checksum
    data_pkt(32'd0, 16'd10, 8'hA5);                                 // name
    data_pkt(32'd30, 16'd5, 8'h01);                                 // stored
    data_pkt(32'd30, 16'd6, 8'h02);                                 // overwrite
    data_pkt(32'd20, 16'd10, 8'h03);                                // stored
    data_pkt(32'd36, 16'hFFFF, 8'hFF);                              // stored
    data_pkt(32'd10, 16'd10, 8'h04);                                // drains three
    data_pkt(32'd10, 16'd10, 8'h05);                                // duplicate
    send_hdr(OP_TICK, 1, 0, 0, 0, 0, '0, '0, '0);
    send_hdr(OP_PKT, 1, 0, 0, 1, 1, 32'hFFFF_FFFF, 16'd3, 8'd3);    // FIN wins
    send_hdr(OP_TICK, 0, 0, 0, 0, 0, '0, '0, '0);
    send_hdr(OP_PKT, 1, 1, 0, 0, 1, 32'd9, 16'd9, 8'd9);
    send_hdr(OP_PKT, 0, 0, 1, 0, 0, '0, '0, '0);                    // closes
    send_hdr(OP_PKT, 1, 1, 0, 0, 0, 32'd0, 16'd0, 8'd0);
    for (int i = 0; i < 18; i++)                                    // fills the table
      data_pkt(32'd100 + i, 16'd1, 8'(i));
    send_hdr(OP_PKT, 1, 0, 1, 1, 0, '0, '0, '0);
    send_hdr(OP_PKT, 1, 0, 1, 0, 0, '0, '0, '0);

    // random sessions in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 7 : 0;
      while (sent < 140 * (ph + 1)) begin
        if ($urandom_range(5) == 0) noise();
        else session();
      end
      if (ph == 0) go_idle();   // hold off until every result is out
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0)
      $display("reliable_receiver_reorder_top regression: pass");
    else
      $display("reliable_receiver_reorder_top regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
